// ===== rtl/nes_pkg.sv =====
// ============================================================================
// nes_pkg - shared types and constants for the nonzero extent scanner
// Field widths, register reset values, register indexes and the op record
// passed from the front end to the extent tracker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package nes_pkg;

  localparam int ADDR_W     = 48;
  localparam int CHUNK_W    = 32;
  localparam int CLEN_W     = CHUNK_W + 1;
  localparam int CFG_W      = ADDR_W;
  localparam int CFG_IDX_W  = 1;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [ADDR_W-1:0]  HEADER_SIZE_RESET = ADDR_W'(52428800);
  localparam logic [CHUNK_W-1:0] CHUNK_SIZE_RESET  = CHUNK_W'(52428800);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_HEADER_SIZE = 1'b0,
    CFG_CHUNK_SIZE  = 1'b1
  } cfg_reg_t;

  typedef enum logic {
    OP_HEADER = 1'b0,
    OP_CHUNK  = 1'b1
  } op_kind_t;

  // one op per header byte and per completed chunk
  typedef struct packed {
    op_kind_t          kind;
    logic              last;
    logic              has_data;
    logic [CLEN_W-1:0] clen;
    logic [ADDR_W-1:0] chunk_start;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

`default_nettype wire

// ===== rtl/nes_in_if.sv =====
// ============================================================================
// nes_in_if - image byte stream channel
// valid/ready handshake carrying one image byte and its end-of-image flag.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface nes_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

`default_nettype wire

// ===== rtl/nes_out_if.sv =====
// ============================================================================
// nes_out_if - extent result channel
// valid/ready handshake carrying one extent (start, length, final flag).
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface nes_out_if;
  import nes_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] extent_start;
  logic [ADDR_W-1:0] extent_length;
  logic              final_extent;

  modport source (output valid, output extent_start, output extent_length,
                  output final_extent, input ready);
  modport sink   (input valid, input extent_start, input extent_length,
                  input final_extent, output ready);
endinterface

`default_nettype wire

// ===== rtl/nes_front.sv =====
// ============================================================================
// nes_front - byte classifier
// Holds the configuration registers, tracks position and chunk boundaries,
// and turns header bytes and completed chunks into ops for the tracker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nes_front (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    cfg_we,
  input  wire logic [nes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nes_pkg::CFG_W-1:0]     cfg_data,
  nes_in_if.sink                       in_chan,
  input  wire nes_pkg::fifo_stat_t     q_stat,
  output logic                         op_push,
  output nes_pkg::op_t                 op_data
);
  import nes_pkg::*;

  logic [ADDR_W-1:0]  header_size_r;
  logic [CHUNK_W-1:0] chunk_size_r;

  logic [ADDR_W-1:0]  pos_r, pos_nxt;
  logic [CHUNK_W-1:0] offset_r, offset_nxt;
  logic [ADDR_W-1:0]  chunk_start_r, chunk_start_nxt;
  logic               has_data_r, has_data_nxt;

  logic               acc;
  logic               in_hdr;
  logic               first_of_chunk;
  logic [ADDR_W-1:0]  pos_inc;
  logic [CLEN_W-1:0]  clen;
  logic               done;
  logic               nd;
  logic [ADDR_W-1:0]  start_c;

  assign in_chan.ready = !q_stat.full;
  assign acc           = in_chan.valid && in_chan.ready;

  always_comb begin
    in_hdr         = (pos_r < header_size_r);
    first_of_chunk = (offset_r == '0);
    pos_inc        = (pos_r == {ADDR_W{1'b1}}) ? pos_r : pos_r + ADDR_W'(1);
    clen           = {1'b0, offset_r} + CLEN_W'(1);
    // a chunk size of zero behaves as one since clen is never below it
    done           = in_chan.last_byte || (clen >= {1'b0, chunk_size_r});
    nd             = (first_of_chunk ? 1'b0 : has_data_r) || (in_chan.data_byte != 8'd0);
    start_c        = first_of_chunk ? pos_r : chunk_start_r;

    op_push              = acc && (in_hdr || done);
    op_data.kind         = in_hdr ? OP_HEADER : OP_CHUNK;
    op_data.last         = in_chan.last_byte;
    op_data.has_data     = nd;
    op_data.clen         = clen;
    op_data.chunk_start  = start_c;

    pos_nxt         = pos_r;
    offset_nxt      = offset_r;
    chunk_start_nxt = chunk_start_r;
    has_data_nxt    = has_data_r;
    if (acc) begin
      if (in_chan.last_byte) begin
        pos_nxt         = '0;
        offset_nxt      = '0;
        chunk_start_nxt = '0;
        has_data_nxt    = 1'b0;
      end else begin
        pos_nxt = pos_inc;
        if (!in_hdr) begin
          chunk_start_nxt = start_c;
          has_data_nxt    = nd;
          offset_nxt      = done ? '0 : clen[CHUNK_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_size_r <= HEADER_SIZE_RESET;
      chunk_size_r  <= CHUNK_SIZE_RESET;
      pos_r         <= '0;
      offset_r      <= '0;
      chunk_start_r <= '0;
      has_data_r    <= 1'b0;
    end else begin
      pos_r         <= pos_nxt;
      offset_r      <= offset_nxt;
      chunk_start_r <= chunk_start_nxt;
      has_data_r    <= has_data_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_HEADER_SIZE: header_size_r <= cfg_data[ADDR_W-1:0];
          CFG_CHUNK_SIZE:  chunk_size_r  <= cfg_data[CHUNK_W-1:0];
          default: ;
        endcase
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nes_op_fifo.sv =====
// ============================================================================
// nes_op_fifo - op queue
// Short FIFO between the classifier and the extent tracker.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nes_op_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire nes_pkg::op_t  push_op,
  input  wire logic          pop,
  output nes_pkg::op_t       head_op,
  output nes_pkg::fifo_stat_t stat
);
  import nes_pkg::*;

  op_t                   mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push;
  logic                  do_pop;

  always_comb begin
    stat.full  = (cnt_r == FIFO_CNT_W'(FIFO_DEPTH));
    stat.empty = (cnt_r == '0);
    do_push    = push && !stat.full;
    do_pop     = pop && !stat.empty;
    wr_ptr_nxt = do_push ? wr_ptr_r + FIFO_PTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + FIFO_PTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + FIFO_CNT_W'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - FIFO_CNT_W'(1);
  end

  assign head_op = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wr_ptr_r] <= push_op;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/nes_back.sv =====
// ============================================================================
// nes_back - extent tracker
// Applies header and chunk ops to the open extent and registers any extent
// that closes onto the result channel.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module nes_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire nes_pkg::fifo_stat_t q_stat,
  input  wire nes_pkg::op_t        op,
  output logic                     op_pop,
  nes_out_if.source                out_chan
);
  import nes_pkg::*;

  logic              open_r, open_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] len_r, len_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_start_r;
  logic [ADDR_W-1:0] out_len_r;
  logic              out_final_r;

  logic              can_adv;
  logic [ADDR_W:0]   addend;
  logic [ADDR_W:0]   sum;
  logic [ADDR_W-1:0] sat_len;
  logic              emit;
  logic [ADDR_W-1:0] e_start;
  logic [ADDR_W-1:0] e_len;
  logic              e_final;

  assign can_adv = !out_valid_r || out_chan.ready;
  assign op_pop  = !q_stat.empty && can_adv;

  always_comb begin
    addend  = (op.kind == OP_HEADER) ? (ADDR_W+1)'(1) : (ADDR_W+1)'(op.clen);
    sum     = {1'b0, len_r} + addend;
    sat_len = sum[ADDR_W] ? {ADDR_W{1'b1}} : sum[ADDR_W-1:0];

    open_nxt  = open_r;
    start_nxt = start_r;
    len_nxt   = len_r;
    emit      = 1'b0;
    e_start   = start_r;
    e_len     = len_r;
    e_final   = op.last;

    case (op.kind)
      OP_HEADER: begin
        open_nxt = 1'b1;
        len_nxt  = sat_len;
        e_len    = sat_len;
        emit     = op.last;
      end
      OP_CHUNK: begin
        if (op.has_data) begin
          if (!open_r) begin
            start_nxt = op.chunk_start;
            len_nxt   = ADDR_W'(op.clen);
          end else begin
            len_nxt   = sat_len;
          end
          open_nxt = 1'b1;
          e_start  = start_nxt;
          e_len    = len_nxt;
          emit     = op.last;
        end else if (open_r) begin
          // empty chunk closes the open extent
          emit      = 1'b1;
          open_nxt  = 1'b0;
          start_nxt = '0;
          len_nxt   = '0;
        end
      end
      default: ;
    endcase

    // end of image: back to the header extent
    if (op.last) begin
      open_nxt  = 1'b1;
      start_nxt = '0;
      len_nxt   = '0;
    end

    if (op_pop)               out_valid_nxt = emit;
    else if (out_chan.ready)  out_valid_nxt = 1'b0;
    else                      out_valid_nxt = out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= 1'b1;
      start_r     <= '0;
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (op_pop) begin
        open_r  <= open_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (op_pop && emit) begin
      out_start_r <= e_start;
      out_len_r   <= e_len;
      out_final_r <= e_final;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.extent_start  = out_start_r;
  assign out_chan.extent_length = out_len_r;
  assign out_chan.final_extent  = out_final_r;

endmodule

`default_nettype wire

// ===== rtl/nonzero_extent_scanner_core.sv =====
// ============================================================================
// nonzero_extent_scanner_core - nonzero extent scanner top level
// Byte classifier, op queue and extent tracker.
// ============================================================================
// Throughput: one byte per cycle while the op queue has room; the classifier
//   and tracker each handle one op a cycle when not stalled, decoupled by a
//   four-entry op queue. An extent closed by a byte passes the op queue and
//   is then registered by the tracker; result-side stalls hold it there.
// Reset: synchronous, active low; registers return to 52428800, the header
//   extent is open at address zero and the queue is emptied.
`timescale 1ns / 1ps
`default_nettype none

module nonzero_extent_scanner_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [nes_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [nes_pkg::CFG_W-1:0]     cfg_data,
  nes_in_if.sink                             in_chan,
  nes_out_if.source                          out_chan
);
  import nes_pkg::*;

  logic       op_push;
  op_t        push_op;
  logic       op_pop;
  op_t        head_op;
  fifo_stat_t q_stat;

  nes_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_chan   (in_chan),
    .q_stat    (q_stat),
    .op_push   (op_push),
    .op_data   (push_op)
  );

  nes_op_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (op_push),
    .push_op (push_op),
    .pop     (op_pop),
    .head_op (head_op),
    .stat    (q_stat)
  );

  nes_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_stat   (q_stat),
    .op       (head_op),
    .op_pop   (op_pop),
    .out_chan (out_chan)
  );

endmodule

`default_nettype wire
